/* src/alr_pkg.sv */
// Package for the antialiased line rasterizer: widths, payload structs,
// controller/datapath command and status types. No dependencies.
package alr_pkg;
  localparam int CoordBits = 12;
  localparam int FracBits = 24;
  localparam int CovBits = 8;
  localparam int OutBits = CoordBits + 1;
  localparam int InterpBits = CoordBits + FracBits + 2;
  localparam int SlopeBits = FracBits + 3;
  localparam int DivBits = CoordBits + FracBits;

  localparam logic CMD_NEW_LINE = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [CoordBits-1:0] start_x;
    logic [CoordBits-1:0] start_y;
    logic [CoordBits-1:0] end_x;
    logic [CoordBits-1:0] end_y;
  } in_beat_t;

  typedef struct packed {
    logic [OutBits-1:0] pixel_a_x;
    logic [OutBits-1:0] pixel_a_y;
    logic [OutBits-1:0] pixel_b_x;
    logic [OutBits-1:0] pixel_b_y;
    logic [CovBits-1:0] coverage_a;
    logic [CovBits-1:0] coverage_b;
    logic               last_column;
  } out_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic setup;      // latch endpoints, order them, load divider
    logic div_step;   // one restoring division step
    logic finish;     // apply gradient, build first endpoint column
    logic emit_end;   // build second endpoint column
    logic emit_mid;   // build interior column and advance
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic has_interior;  // major_position < major_end
    logic mid_last;      // major_position + 1 >= major_end
  } dp_status_t;
endpackage

/* src/alr_datapath.sv */
// Datapath of the rasterizer: endpoint setup, serial gradient divider,
// interpolator and column formatting. Depends on alr_pkg.
module alr_datapath (
  input  logic               clk,
  input  alr_pkg::in_beat_t  in_beat,
  input  alr_pkg::dp_cmd_t   cmd,
  output alr_pkg::dp_status_t status,
  output alr_pkg::out_beat_t column
);
  localparam int CB = alr_pkg::CoordBits;
  localparam int FB = alr_pkg::FracBits;
  localparam int OB = alr_pkg::OutBits;
  localparam int IB = alr_pkg::InterpBits;
  localparam int SB = alr_pkg::SlopeBits;
  localparam int DB = alr_pkg::DivBits;
  localparam int CntBits = $clog2(DB + 1);

  logic          steep;
  logic          neg;
  logic [CB-1:0] n0;
  logic [OB-1:0] major_position;
  logic [OB-1:0] major_end;
  logic [OB-1:0] end_minor;
  logic [IB-1:0] interp_y;
  logic [SB-1:0] slope;
  logic [CB-1:0] dmaj;
  logic [DB-1:0] quot;
  logic [CB:0]   rem;
  logic [CntBits-1:0] cnt;

  // Setup: steepness and ordering of the endpoints
  logic [CB-1:0] adx, ady, j0, j1, m0, m1, sj0, sj1, sn0, sn1;
  logic          st;
  always_comb begin
    adx = (in_beat.start_x > in_beat.end_x) ? in_beat.start_x - in_beat.end_x
                                            : in_beat.end_x - in_beat.start_x;
    ady = (in_beat.start_y > in_beat.end_y) ? in_beat.start_y - in_beat.end_y
                                            : in_beat.end_y - in_beat.start_y;
    st = ady > adx;
    j0 = st ? in_beat.start_y : in_beat.start_x;
    m0 = st ? in_beat.start_x : in_beat.start_y;
    j1 = st ? in_beat.end_y : in_beat.end_x;
    m1 = st ? in_beat.end_x : in_beat.end_y;
    sj0 = (j0 > j1) ? j1 : j0;
    sj1 = (j0 > j1) ? j0 : j1;
    sn0 = (j0 > j1) ? m1 : m0;
    sn1 = (j0 > j1) ? m0 : m1;
  end

  // Restoring division step: shift in next dividend bit (MSB first)
  logic [CB+1:0] trial;
  always_comb begin
    trial = {rem, quot[DB-1]} - {2'b00, dmaj};
  end

  // Column formatting
  logic [OB-1:0] c_major, c_minor;
  logic [FB-1:0] frac;
  logic [FB:0]   rfrac;
  always_comb begin
    frac = interp_y[FB-1:0];
    rfrac = (FB+1)'(1) << FB;
    rfrac = rfrac - {1'b0, frac};
    c_major = major_position;
    c_minor = interp_y[FB +: OB];
    if (cmd.finish) begin
      c_major = major_position - OB'(1);
      c_minor = OB'(n0);
    end else if (cmd.emit_end) begin
      c_major = major_end;
      c_minor = end_minor;
    end
  end

  function automatic logic [alr_pkg::CovBits-1:0] sat_cov(input logic [FB:0] f);
    logic [FB+alr_pkg::CovBits:0] c;
    c = {f, {alr_pkg::CovBits{1'b0}}} >> FB;
    sat_cov = (c > {{(FB+1){1'b0}}, {alr_pkg::CovBits{1'b1}}})
              ? {alr_pkg::CovBits{1'b1}} : c[alr_pkg::CovBits-1:0];
  endfunction

  logic [alr_pkg::CovBits-1:0] half_cov;
  assign half_cov = sat_cov((FB+1)'(1) << (FB - 1));

  logic [OB-1:0] mb;
  logic [alr_pkg::CovBits-1:0] ca, cb;
  always_comb begin
    mb = c_minor + OB'(1);
    if (cmd.emit_mid) begin
      ca = sat_cov(rfrac);
      cb = sat_cov({1'b0, frac});
    end else begin
      ca = half_cov;
      cb = '0;
    end
  end

  logic [IB-1:0] slope_ext;
  assign slope_ext = {{(IB-SB){slope[SB-1]}}, slope};
  logic [SB-1:0] mag;
  assign mag = SB'(quot);

  // Register state and the output column
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      steep <= st;
      dmaj <= sj1 - sj0;
      neg <= sn1 < sn0;
      n0 <= sn0;
      major_end <= OB'(sj1);
      end_minor <= OB'(sn1);
      major_position <= OB'(sj0) + OB'(1);
      quot <= {((sn1 >= sn0) ? sn1 - sn0 : sn0 - sn1), {FB{1'b0}}};
      rem <= '0;
      cnt <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[CB+1]) begin
        rem <= trial[CB:0];
        quot <= {quot[DB-2:0], 1'b1};
      end else begin
        rem <= {rem[CB-1:0], quot[DB-1]};
        quot <= {quot[DB-2:0], 1'b0};
      end
      cnt <= cnt + CntBits'(1);
    end
    if (cmd.finish) begin
      // coincident endpoints: a zero divisor fills the quotient, force zero
      slope <= (dmaj == '0) ? '0 : (neg ? SB'(0) - mag : mag);
      interp_y <= neg ? ({{(IB-CB){1'b0}}, n0} << FB) - IB'(dmaj == '0 ? '0 : mag)
                      : ({{(IB-CB){1'b0}}, n0} << FB) + IB'(dmaj == '0 ? '0 : mag);
    end
    if (cmd.emit_mid) begin
      major_position <= major_position + OB'(1);
      interp_y <= interp_y + slope_ext;
    end
    if (cmd.finish || cmd.emit_end || cmd.emit_mid) begin
      column.pixel_a_x <= steep ? c_minor : c_major;
      column.pixel_a_y <= steep ? c_major : c_minor;
      column.pixel_b_x <= steep ? mb : c_major;
      column.pixel_b_y <= steep ? c_major : mb;
      column.coverage_a <= ca;
      column.coverage_b <= cb;
      column.last_column <= cmd.emit_end ? !(major_position < major_end)
                          : (cmd.emit_mid ? status.mid_last : 1'b0);
    end
  end

  assign status.div_done = (cnt == CntBits'(DB));
  assign status.has_interior = major_position < major_end;
  assign status.mid_last = (major_position + OB'(1)) >= major_end;
endmodule

/* src/alr_ctrl.sv */
// Controller for the rasterizer: sequences setup, division and column
// output, and runs the output handshake. Depends on alr_pkg.
module alr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_cmd,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  alr_pkg::dp_status_t status,
  output alr_pkg::dp_cmd_t    cmd
);
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;
  typedef enum logic [1:0] {P_NONE, P_END, P_MID} phase_t;
  state_t state;
  phase_t phase;

  logic acc;
  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    if (acc && in_cmd == alr_pkg::CMD_NEW_LINE) cmd.setup = 1'b1;
    if (state == S_DIV && !status.div_done) cmd.div_step = 1'b1;
    if (state == S_DIV && status.div_done) cmd.finish = 1'b1;
    if (acc && in_cmd == alr_pkg::CMD_ADVANCE && phase == P_END) cmd.emit_end = 1'b1;
    if (acc && in_cmd == alr_pkg::CMD_ADVANCE && phase == P_MID && status.has_interior)
      cmd.emit_mid = 1'b1;
  end

  // Hold state, phase and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= P_NONE;
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
      state <= S_OUT;
      phase <= P_END;
    end else if (acc) begin
      if (cmd.setup) begin
        out_valid <= 1'b0;
        state <= S_DIV;
      end else if (cmd.emit_end) begin
        out_valid <= 1'b1;
        state <= S_OUT;
        phase <= status.has_interior ? P_MID : P_NONE;
      end else if (cmd.emit_mid) begin
        out_valid <= 1'b1;
        state <= S_OUT;
        if (status.mid_last) phase <= P_NONE;
      end else begin
        out_valid <= 1'b0;
        state <= S_IDLE;
        phase <= P_NONE;
      end
    end else if (state == S_OUT && out_ready) begin
      out_valid <= 1'b0;
      state <= S_IDLE;
    end
  end
endmodule

/* src/antialiased_line_rasterizer.sv */
// Top level of the antialiased line rasterizer: controller plus datapath.
// Depends on alr_pkg, alr_ctrl and alr_datapath.
//
// A new-line beat's first column appears once the divider finishes: the
// gradient comes from a one-bit-per-cycle restoring divider over 36 quotient
// bits. An advance beat yields its column in the cycle after acceptance, and
// the next beat is accepted in the cycle that column is taken, so columns
// stream at one per cycle under continuous ready. Advance beats with no
// line active produce nothing.
module antialiased_line_rasterizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  alr_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output alr_pkg::out_beat_t out_data
);
  alr_pkg::dp_cmd_t    cmd;
  alr_pkg::dp_status_t status;

  alr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_cmd(in_data.cmd),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .cmd(cmd)
  );

  alr_datapath u_dp (
    .clk(clk), .in_beat(in_data), .cmd(cmd), .status(status), .column(out_data)
  );

  // Only one of the column builders fires in a cycle
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.finish, cmd.emit_end, cmd.emit_mid}))
    else $error("multiple column commands");
  // No column command while a result still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(cmd.finish || cmd.emit_end || cmd.emit_mid))
    else $error("column overwritten");
  // A setup is always followed by division work
  a_setup_div: assert property (@(posedge clk) disable iff (rst)
    cmd.setup |=> (cmd.div_step || cmd.setup))
    else $error("division did not start");
endmodule
